// File: rtl/nvr_pkg.sv
// ----------------------------------------------------------------------------
// nvr_pkg
// Shared widths, constants and pipeline payload types for the normal-vector
// renormalizer.
// ----------------------------------------------------------------------------
package nvr_pkg;

  localparam int CompW  = 8;
  localparam int SqW    = 2 * CompW;
  localparam int SumW   = SqW + 2;
  localparam int RhsW   = 32;
  localparam int LhsW   = SqW + SumW;
  localparam int Lanes  = 3;
  localparam int Steps  = CompW;
  localparam logic [SqW-1:0] Scale = SqW'(65025);

  // per-component search state
  typedef struct packed {
    logic [CompW-1:0] k;
    logic             dneg;
    logic [RhsW-1:0]  rhs;
  } lane_t;

  // one pixel moving through the search stages
  typedef struct packed {
    logic [SumW-1:0]     sum;
    lane_t [Lanes-1:0]   lane;
  } item_t;

endpackage

// File: rtl/nvr_if.sv
// ----------------------------------------------------------------------------
// nvr_in_if / nvr_out_if
// Valid/ready channels carrying one RGB8 pixel request.
// ----------------------------------------------------------------------------
interface nvr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface nvr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// File: rtl/nvr_prep.sv
// ----------------------------------------------------------------------------
// nvr_prep
// Unpacks bytes to odd components, squares them, then forms the squared
// length and the scaled right-hand side of the compare (two stages).
// ----------------------------------------------------------------------------
module nvr_prep (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic [nvr_pkg::Lanes-1:0][nvr_pkg::CompW-1:0] byte_i,
  output logic                                    valid_o,
  output nvr_pkg::item_t                          item_o
);

  logic [nvr_pkg::Lanes-1:0][nvr_pkg::SqW-1:0] sq_d, sq_q;
  logic [nvr_pkg::Lanes-1:0]                   neg_d, neg_q;
  logic                                        valid1_q, valid2_q;
  nvr_pkg::item_t                              item_d, item_q;

  // stage 1: magnitude of 2b-255 and its square
  always_comb begin
    logic [nvr_pkg::CompW-1:0] ad;
    for (int i = 0; i < nvr_pkg::Lanes; i++) begin
      neg_d[i] = ~byte_i[i][nvr_pkg::CompW-1];
      ad = neg_d[i] ? ~{byte_i[i][nvr_pkg::CompW-2:0], 1'b0}
                    : {byte_i[i][nvr_pkg::CompW-2:0], 1'b1};
      sq_d[i] = nvr_pkg::SqW'(ad) * nvr_pkg::SqW'(ad);
    end
  end

  // stage 2: squared length and scaled squares, search starts at k = 0
  always_comb begin
    item_d.sum = nvr_pkg::SumW'(sq_q[0]) + nvr_pkg::SumW'(sq_q[1])
               + nvr_pkg::SumW'(sq_q[2]);
    for (int i = 0; i < nvr_pkg::Lanes; i++) begin
      item_d.lane[i].k    = '0;
      item_d.lane[i].dneg = neg_q[i];
      item_d.lane[i].rhs  = nvr_pkg::RhsW'(nvr_pkg::Scale) * nvr_pkg::RhsW'(sq_q[i]);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= sq_d;
      neg_q  <= neg_d;
      item_q <= item_d;
    end
  end

  assign valid_o = valid2_q;
  assign item_o  = item_q;

endmodule

// File: rtl/nvr_step.sv
// ----------------------------------------------------------------------------
// nvr_step
// One bit of the binary search for the output byte, in two stages: square
// of the trial odd value, then compare of m^2*S against 65025*d^2.
// ----------------------------------------------------------------------------
module nvr_step #(
  parameter int Bit = 7
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  nvr_pkg::item_t item_i,
  output logic           valid_o,
  output nvr_pkg::item_t item_o
);

  logic [nvr_pkg::Lanes-1:0][nvr_pkg::CompW-1:0] kt_d, kt_q;
  logic [nvr_pkg::Lanes-1:0][nvr_pkg::SqW-1:0]   sq_d, sq_q;
  nvr_pkg::item_t                                a_q, item_d, item_q;
  logic                                          valid_a_q, valid_b_q;

  // stage a: trial byte, |2k-255| squared
  always_comb begin
    logic [nvr_pkg::CompW-1:0] am;
    for (int i = 0; i < nvr_pkg::Lanes; i++) begin
      kt_d[i] = item_i.lane[i].k | (nvr_pkg::CompW'(1) << Bit);
      am = kt_d[i][nvr_pkg::CompW-1] ? {kt_d[i][nvr_pkg::CompW-2:0], 1'b1}
                                     : ~{kt_d[i][nvr_pkg::CompW-2:0], 1'b0};
      sq_d[i] = nvr_pkg::SqW'(am) * nvr_pkg::SqW'(am);
    end
  end

  // stage b: keep the trial bit when the trial still fits below
  always_comb begin
    logic [nvr_pkg::LhsW-1:0] lhs;
    logic [nvr_pkg::LhsW-1:0] rhs;
    logic                     mpos;
    logic                     fits;
    item_d = a_q;
    for (int i = 0; i < nvr_pkg::Lanes; i++) begin
      lhs  = nvr_pkg::LhsW'(sq_q[i]) * nvr_pkg::LhsW'(a_q.sum);
      rhs  = nvr_pkg::LhsW'(a_q.lane[i].rhs);
      mpos = kt_q[i][nvr_pkg::CompW-1];
      if (!mpos && !a_q.lane[i].dneg) begin
        fits = 1'b1;
      end else if (mpos && a_q.lane[i].dneg) begin
        fits = 1'b0;
      end else if (mpos) begin
        fits = (lhs <= rhs);
      end else begin
        fits = (lhs >= rhs);
      end
      item_d.lane[i].k = fits ? kt_q[i] : a_q.lane[i].k;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kt_q   <= kt_d;
      sq_q   <= sq_d;
      a_q    <= item_i;
      item_q <= item_d;
    end
  end

  assign valid_o = valid_b_q;
  assign item_o  = item_q;

endmodule

// File: rtl/normal_vector_renormalizer_top.sv
// Stages: 2 prep stages, then 8 search bits of 2 stages each.
// Throughput: one pixel per cycle; the whole pipeline holds while the output
// register waits on ready.
// Reset: asynchronous active-low, clears all valid bits; no other state.
// ----------------------------------------------------------------------------
// normal_vector_renormalizer_top
// Renormalizes one RGB8 normal-map pixel per cycle while the output is not held,
// with exact integer math.
module normal_vector_renormalizer_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  nvr_in_if.sink           in_i,
  nvr_out_if.source        out_o
);

  logic                                         en;
  logic [nvr_pkg::Steps:0]                      valid;
  nvr_pkg::item_t                               item [nvr_pkg::Steps+1];
  logic [nvr_pkg::Lanes-1:0][nvr_pkg::CompW-1:0] bytes;

  // global advance: move whenever the output slot is free or being taken
  assign en         = ~valid[nvr_pkg::Steps] | out_o.ready;
  assign in_i.ready = en;

  assign bytes[0] = in_i.red_in;
  assign bytes[1] = in_i.green_in;
  assign bytes[2] = in_i.blue_in;

  nvr_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .byte_i  (bytes),
    .valid_o (valid[0]),
    .item_o  (item[0])
  );

  // search chain, most significant bit first
  for (genvar s = 0; s < nvr_pkg::Steps; s++) begin : g_step
    nvr_step #(.Bit(nvr_pkg::Steps - 1 - s)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid[s]),
      .item_i  (item[s]),
      .valid_o (valid[s+1]),
      .item_o  (item[s+1])
    );
  end

  assign out_o.valid     = valid[nvr_pkg::Steps];
  assign out_o.red_out   = item[nvr_pkg::Steps].lane[0].k;
  assign out_o.green_out = item[nvr_pkg::Steps].lane[1].k;
  assign out_o.blue_out  = item[nvr_pkg::Steps].lane[2].k;

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams RGB8 normal-map pixels through the renormalizer under random and
// directed flow control and checks every renormalized pixel against an exact
// integer predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  localparam int PipeLatency = 18;
  localparam longint CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  nvr_in_if  in_ch ();
  nvr_out_if out_ch ();

  normal_vector_renormalizer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  pixel_t     normals_q[$];
  int         mismatch_cnt = 0;
  longint     cycle_cnt = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  bit         recv_hold = 1'b0;

  // clock
  always #5 clk_i = ~clk_i;

  // known values from the start
  initial begin
    in_ch.valid    = 1'b0;
    in_ch.red_in   = '0;
    in_ch.green_in = '0;
    in_ch.blue_in  = '0;
    out_ch.ready   = 1'b0;
  end

  // true when (2k - 255) * sqrt(s) <= 255 * d
  function automatic bit below_limit(int m, int d, longint unsigned s);
    longint unsigned am;
    longint unsigned ad;
    longint unsigned lhs;
    longint unsigned rhs;
    am = (m < 0) ? -m : m;
    ad = (d < 0) ? -d : d;
    lhs = am * am * s;
    rhs = 64'd65025 * ad * ad;
    if (m <= 0 && d >= 0) return 1'b1;
    if (m > 0 && d < 0) return 1'b0;
    if (m > 0) return lhs <= rhs;
    return lhs >= rhs;
  endfunction

  function automatic logic [7:0] pack_byte(int d, longint unsigned s);
    for (int k = 255; k > 0; k--) begin
      if (below_limit(2 * k - 255, d, s)) return 8'(k);
    end
    return 8'd0;
  endfunction

  function automatic pixel_t renormalize(pixel_t p);
    int dr;
    int dg;
    int db;
    longint unsigned s;
    pixel_t r;
    dr = 2 * int'(p.red) - 255;
    dg = 2 * int'(p.green) - 255;
    db = 2 * int'(p.blue) - 255;
    s = dr * dr + dg * dg + db * db;
    r.red   = pack_byte(dr, s);
    r.green = pack_byte(dg, s);
    r.blue  = pack_byte(db, s);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp);
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
    mismatch_cnt++;
  endtask

  // send one pixel request, with random idle cycles first
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_t exp_px;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.red_in   <= r;
    in_ch.green_in <= g;
    in_ch.blue_in  <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    exp_px = renormalize('{r, g, b});
    normals_q = {normals_q, exp_px};
  endtask

  // sender goes quiet until every expected result has come
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (normals_q.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 4) @(posedge clk_i);
  endtask

  // receiver ready, random stall or long hold
  always @(posedge clk_i) begin
    if (rst_ni) out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    pixel_t exp_px;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (normals_q.size() == 0) begin
        $display("unexpected result %0d %0d %0d", out_ch.red_out, out_ch.green_out,
                 out_ch.blue_out);
        mismatch_cnt++;
      end else begin
        exp_px = normals_q.pop_front();
        if (out_ch.red_out !== exp_px.red) report_mismatch("red", out_ch.red_out, exp_px.red);
        if (out_ch.green_out !== exp_px.green)
          report_mismatch("green", out_ch.green_out, exp_px.green);
        if (out_ch.blue_out !== exp_px.blue)
          report_mismatch("blue", out_ch.blue_out, exp_px.blue);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // extremes of every byte and the axis directions
  task automatic test_directed();
    logic [7:0] corner[4] = '{8'd0, 8'd127, 8'd128, 8'd255};
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j += 3) begin
        send_pixel(corner[i], corner[j], corner[3 - i]);
      end
    end
    send_pixel(8'd255, 8'd128, 8'd128);
    send_pixel(8'd128, 8'd255, 8'd127);
    send_pixel(8'd127, 8'd127, 8'd0);
    send_pixel(8'd128, 8'd127, 8'd128);
    send_pixel(8'd1, 8'd254, 8'd170);
    send_pixel(8'd170, 8'd85, 8'd255);
  endtask

  // random pixels, mostly upward-facing normals with some full-range noise
  task automatic test_random(int count);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    for (int n = 0; n < count; n++) begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(255, 160));
      send_pixel(r, g, b);
    end
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (60) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      test_random(40);
    join
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 73;
    test_directed();
    test_random(130);
    wait_drained();

    send_idle_pct = 73;
    recv_idle_pct = 34;
    test_random(130);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(130);
    wait_drained();

    if (mismatch_cnt == 0 && normals_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
